// ===== hw/rtl/fllq_pkg.sv =====
// Shared types, constants and controller/datapath structs for the FIFO/LIFO queue.
package fllq_pkg;

   localparam int DEPTH_DEFAULT = 16;

   localparam int REQ_W      = 2;
   localparam int ID_W       = 32;
   localparam int STORE_ID_W = 31;
   localparam int INFO_W     = 32;
   localparam int STATUS_W   = 2;
   localparam int POS_W      = 9;
   localparam int COUNT_W    = 9;
   localparam int PADDR_W    = 3;
   localparam int PDATA_W    = 32;

   localparam logic [0:0] CSR_IDX_FIFO_MODE = 1'b0;
   localparam logic       FIFO_MODE_RESET   = 1'b1;

   typedef enum logic [REQ_W-1:0] {
      REQ_PUSH  = 2'd0,
      REQ_PULL  = 2'd1,
      REQ_FIND  = 2'd2,
      REQ_CLEAR = 2'd3
   } req_code_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_INVALID = 2'd1,
      STATUS_EMPTY   = 2'd2,
      STATUS_FULL    = 2'd3
   } status_code_type;

   typedef struct packed {
      logic            capture;
      logic            set_status;
      status_code_type status_code;
      logic            push_write;
      logic            pull_read;
      logic            pull_take;
      logic            scan_start;
      logic            scan_step;
      logic            set_found;
      logic            clear;
      logic            next_read;
      logic            next_take;
      logic            next_empty;
      logic            load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      req_code_type req_code;
      logic         data_ok;
      logic         full;
      logic         empty;
      logic         pend;
      logic         match;
      logic         scan_end;
   } dp_stat_type;

endpackage

// ===== hw/rtl/fllq_if.sv =====
// Request and response channel interfaces (valid/ready with payload).
interface fllq_req_if;
   logic                          valid;
   logic                          ready;
   logic [fllq_pkg::REQ_W-1:0]    req_type;
   logic signed [fllq_pkg::ID_W-1:0] item_id;
   logic [fllq_pkg::INFO_W-1:0]   info_word;
   logic                          info_present;

   modport source (output valid, req_type, item_id, info_word, info_present, input ready);
   modport sink   (input valid, req_type, item_id, info_word, info_present, output ready);
endinterface

interface fllq_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [fllq_pkg::STATUS_W-1:0]    status;
   logic signed [fllq_pkg::ID_W-1:0] pulled_id;
   logic [fllq_pkg::INFO_W-1:0]      pulled_info;
   logic                             found;
   logic signed [fllq_pkg::POS_W-1:0] position;
   logic signed [fllq_pkg::ID_W-1:0] next_id;
   logic [fllq_pkg::COUNT_W-1:0]     entry_count;

   modport source (output valid, status, pulled_id, pulled_info, found, position, next_id,
                   entry_count, input ready);
   modport sink   (input valid, status, pulled_id, pulled_info, found, position, next_id,
                   entry_count, output ready);
endinterface

// ===== hw/rtl/fifo_lifo_queue_with_search_core.sv =====
// Top level of the FIFO/LIFO queue with identifier search.
// Usage:
//   Requests enter on req_ch (valid/ready): push, pull, find or clear, with an
//   identifier, an information word and its presence flag. Each request gives
//   exactly one response on rsp_ch with status, pulled entry, find result, the
//   identifier the next pull would return and the entry count.
//   The fifo_mode register (APB, byte address 0) picks pull order: 1 oldest
//   first, 0 newest first. Write it only while no request is in flight.
// Sequence:
//   One request is worked at a time: decide, a read wait for a pull that removes an
//   entry, a read of the next identifier (skipped when the store is empty), result
//   load. Find reads the stored entries one per cycle through the single RAM read
//   port until a match or the last entry, before the next-identifier read. The
//   next request is accepted from the cycle after the result is loaded.
// Reset:
//   Synchronous, active high: the store empties and fifo_mode returns to 1.
//   Entry storage is not cleared; only occupied entries are ever read.
// Stall:
//   While rsp ready is low the response register holds its result; the block
//   still takes one more request and holds that result until the slot frees.
module fifo_lifo_queue_with_search_core #(
   parameter int DEPTH = fllq_pkg::DEPTH_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   fllq_req_if.sink                       req_ch,
   fllq_rsp_if.source                     rsp_ch,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [fllq_pkg::PADDR_W-1:0]   paddr,
   input  logic [fllq_pkg::PDATA_W-1:0]   pwdata,
   output logic [fllq_pkg::PDATA_W-1:0]   prdata,
   output logic                           pready
);

   localparam int AW = $clog2(DEPTH);
   localparam int RW = fllq_pkg::STORE_ID_W + fllq_pkg::INFO_W;

   logic                 fifo_mode_ff, fifo_mode_in;
   logic                 csr_write;
   logic                 csr_hit;

   fllq_pkg::dp_cmd_type  cmd;
   fllq_pkg::dp_stat_type stat;

   logic          ram_wr_en;
   logic [AW-1:0] ram_wr_addr;
   logic [RW-1:0] ram_wr_data;
   logic          ram_rd_en;
   logic [AW-1:0] ram_rd_addr;
   logic [RW-1:0] ram_rd_data;

   // Configuration port: zero-wait APB, one register.
   assign pready    = 1'b1;
   assign csr_hit   = (paddr[2] == fllq_pkg::CSR_IDX_FIFO_MODE);
   assign csr_write = psel && penable && pwrite && pready && csr_hit;

   always_comb begin
      fifo_mode_in = fifo_mode_ff;
      if (csr_write) begin
         fifo_mode_in = pwdata[0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_mode_ff <= fllq_pkg::FIFO_MODE_RESET;
      end else begin
         fifo_mode_ff <= fifo_mode_in;
      end
   end

   assign prdata = csr_hit ? {{(fllq_pkg::PDATA_W-1){1'b0}}, fifo_mode_ff} : '0;

   // Sequence each request through the datapath.
   fllq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // Hold pointers, count, the request in flight and the response register.
   fllq_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .fifo_mode       (fifo_mode_ff),
      .cmd             (cmd),
      .stat            (stat),
      .req_type        (req_ch.req_type),
      .item_id         (req_ch.item_id),
      .info_word       (req_ch.info_word),
      .info_present    (req_ch.info_present),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .ram_rd_data     (ram_rd_data),
      .rsp_status      (rsp_ch.status),
      .rsp_pulled_id   (rsp_ch.pulled_id),
      .rsp_pulled_info (rsp_ch.pulled_info),
      .rsp_found       (rsp_ch.found),
      .rsp_position    (rsp_ch.position),
      .rsp_next_id     (rsp_ch.next_id),
      .rsp_entry_count (rsp_ch.entry_count)
   );

   // Entry storage: identifier and information word side by side.
   fllq_ram #(
      .WIDTH (RW),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

endmodule

// ===== hw/rtl/fllq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fllq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/fllq_ctrl.sv =====
// Request sequencer: steps each request through decide, memory reads and result load.
module fllq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  fllq_pkg::dp_stat_type  stat,
   output fllq_pkg::dp_cmd_type   cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_PULL_WAIT,
      ST_FIND,
      ST_NEXT_READ,
      ST_NEXT_WAIT,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            state_in = ST_NEXT_READ;
            case (stat.req_code)
               fllq_pkg::REQ_PUSH: begin
                  if (!stat.data_ok) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = fllq_pkg::STATUS_INVALID;
                  end else if (stat.full) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = fllq_pkg::STATUS_FULL;
                  end else begin
                     cmd.push_write = 1'b1;
                  end
               end
               fllq_pkg::REQ_PULL: begin
                  if (stat.empty) begin
                     cmd.set_status  = 1'b1;
                     cmd.status_code = fllq_pkg::STATUS_EMPTY;
                  end else begin
                     cmd.pull_read = 1'b1;
                     state_in      = ST_PULL_WAIT;
                  end
               end
               fllq_pkg::REQ_FIND: begin
                  cmd.scan_start = 1'b1;
                  state_in       = ST_FIND;
               end
               fllq_pkg::REQ_CLEAR: begin
                  cmd.clear = 1'b1;
               end
               default: begin
                  state_in = ST_NEXT_READ;
               end
            endcase
         end
         ST_PULL_WAIT: begin
            cmd.pull_take = 1'b1;
            state_in      = ST_NEXT_READ;
         end
         ST_FIND: begin
            if (stat.pend && stat.match) begin
               cmd.set_found = 1'b1;
               state_in      = ST_NEXT_READ;
            end else if (!stat.pend && stat.scan_end) begin
               state_in = ST_NEXT_READ;
            end else begin
               cmd.scan_step = 1'b1;
            end
         end
         ST_NEXT_READ: begin
            if (stat.empty) begin
               cmd.next_empty = 1'b1;
               state_in       = ST_OUT;
            end else begin
               cmd.next_read = 1'b1;
               state_in      = ST_NEXT_WAIT;
            end
         end
         ST_NEXT_WAIT: begin
            cmd.next_take = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/fllq_dp.sv =====
// Queue datapath: ring pointers, request capture, search scan and response registers.
module fllq_dp #(
   parameter int DEPTH = fllq_pkg::DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                fifo_mode,
   input  fllq_pkg::dp_cmd_type                cmd,
   output fllq_pkg::dp_stat_type               stat,
   input  logic [fllq_pkg::REQ_W-1:0]          req_type,
   input  logic signed [fllq_pkg::ID_W-1:0]    item_id,
   input  logic [fllq_pkg::INFO_W-1:0]         info_word,
   input  logic                                info_present,
   output logic                                ram_wr_en,
   output logic [$clog2(DEPTH)-1:0]            ram_wr_addr,
   output logic [fllq_pkg::STORE_ID_W+fllq_pkg::INFO_W-1:0] ram_wr_data,
   output logic                                ram_rd_en,
   output logic [$clog2(DEPTH)-1:0]            ram_rd_addr,
   input  logic [fllq_pkg::STORE_ID_W+fllq_pkg::INFO_W-1:0] ram_rd_data,
   output logic [fllq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [fllq_pkg::ID_W-1:0]    rsp_pulled_id,
   output logic [fllq_pkg::INFO_W-1:0]         rsp_pulled_info,
   output logic                                rsp_found,
   output logic signed [fllq_pkg::POS_W-1:0]   rsp_position,
   output logic signed [fllq_pkg::ID_W-1:0]    rsp_next_id,
   output logic [fllq_pkg::COUNT_W-1:0]        rsp_entry_count
);

   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int IDW  = fllq_pkg::ID_W;
   localparam int SIDW = fllq_pkg::STORE_ID_W;
   localparam int IFW  = fllq_pkg::INFO_W;
   localparam int PW   = fllq_pkg::POS_W;

   function automatic logic [AW-1:0] wrap_slot(input logic [AW-1:0] base,
                                                input logic [AW-1:0] off);
      logic [AW:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // control state
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] oldest_ff, oldest_in;
   logic [CW-1:0] rd_k_ff, rd_k_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] pend_k_ff, pend_k_in;

   // captured request
   fllq_pkg::req_code_type    op_ff, op_in;
   logic signed [IDW-1:0]     key_ff, key_in;
   logic [IFW-1:0]            info_ff, info_in;
   logic                      present_ff, present_in;

   // working result
   fllq_pkg::status_code_type status_ff, status_in;
   logic signed [IDW-1:0]     pid_ff, pid_in;
   logic [IFW-1:0]            pinfo_ff, pinfo_in;
   logic                      found_ff, found_in;
   logic signed [PW-1:0]      pos_ff, pos_in;
   logic signed [IDW-1:0]     next_ff, next_in;

   // response register
   logic [fllq_pkg::STATUS_W-1:0] rsp_status_ff;
   logic signed [IDW-1:0]         rsp_pid_ff;
   logic [IFW-1:0]                rsp_pinfo_ff;
   logic                          rsp_found_ff;
   logic signed [PW-1:0]          rsp_pos_ff;
   logic signed [IDW-1:0]         rsp_next_ff;
   logic [CW-1:0]                 rsp_count_ff;

   logic [CW-1:0]   count_m1;
   logic [CW-1:0]   scan_off;
   logic [AW-1:0]   next_slot;
   logic [AW-1:0]   push_slot;
   logic [AW-1:0]   scan_slot;
   logic            scan_end;
   logic [SIDW-1:0] rd_id;
   logic [IFW-1:0]  rd_info;

   assign rd_id    = ram_rd_data[SIDW+IFW-1:IFW];
   assign rd_info  = ram_rd_data[IFW-1:0];
   assign count_m1 = count_ff - CW'(1);
   assign scan_off = fifo_mode ? (count_m1 - rd_k_ff) : rd_k_ff;
   assign next_slot = fifo_mode ? oldest_ff : wrap_slot(oldest_ff, count_m1[AW-1:0]);
   assign push_slot = wrap_slot(oldest_ff, count_ff[AW-1:0]);
   assign scan_slot = wrap_slot(oldest_ff, scan_off[AW-1:0]);
   assign scan_end  = (rd_k_ff >= count_ff);

   assign stat.req_code = op_ff;
   assign stat.data_ok  = (key_ff > 0) && present_ff;
   assign stat.full     = (count_ff == CW'(DEPTH));
   assign stat.empty    = (count_ff == '0);
   assign stat.pend     = pend_ff;
   assign stat.match    = pend_ff && ($unsigned(key_ff) == {1'b0, rd_id});
   assign stat.scan_end = scan_end;

   assign ram_wr_en   = cmd.push_write;
   assign ram_wr_addr = push_slot;
   assign ram_wr_data = {key_ff[SIDW-1:0], info_ff};
   assign ram_rd_en   = cmd.pull_read || cmd.next_read || (cmd.scan_step && !scan_end);
   assign ram_rd_addr = cmd.scan_step ? scan_slot : next_slot;

   always_comb begin
      count_in   = count_ff;
      oldest_in  = oldest_ff;
      rd_k_in    = rd_k_ff;
      pend_in    = pend_ff;
      pend_k_in  = pend_k_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      info_in    = info_ff;
      present_in = present_ff;
      status_in  = status_ff;
      pid_in     = pid_ff;
      pinfo_in   = pinfo_ff;
      found_in   = found_ff;
      pos_in     = pos_ff;
      next_in    = next_ff;

      if (cmd.capture) begin
         op_in      = fllq_pkg::req_code_type'(req_type);
         key_in     = item_id;
         info_in    = info_word;
         present_in = info_present;
         status_in  = fllq_pkg::STATUS_OK;
         pid_in     = '1;
         pinfo_in   = '0;
         found_in   = 1'b0;
         pos_in     = '1;
      end
      if (cmd.set_status) begin
         status_in = cmd.status_code;
      end
      if (cmd.push_write) begin
         count_in = count_ff + CW'(1);
      end
      if (cmd.pull_take) begin
         pid_in   = {1'b0, rd_id};
         pinfo_in = rd_info;
         count_in = count_m1;
         if (fifo_mode) begin
            oldest_in = wrap_slot(oldest_ff, AW'(1));
         end
      end
      if (cmd.scan_start) begin
         rd_k_in = '0;
         pend_in = 1'b0;
      end
      if (cmd.scan_step) begin
         pend_in   = !scan_end;
         pend_k_in = rd_k_ff;
         if (!scan_end) begin
            rd_k_in = rd_k_ff + CW'(1);
         end
      end
      if (cmd.set_found) begin
         found_in = 1'b1;
         pos_in   = PW'(pend_k_ff);
      end
      if (cmd.clear) begin
         count_in  = '0;
         oldest_in = '0;
      end
      if (cmd.next_take) begin
         next_in = {1'b0, rd_id};
      end
      if (cmd.next_empty) begin
         next_in = '1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         oldest_ff <= '0;
         rd_k_ff   <= '0;
         pend_ff   <= 1'b0;
      end else begin
         count_ff  <= count_in;
         oldest_ff <= oldest_in;
         rd_k_ff   <= rd_k_in;
         pend_ff   <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_k_ff  <= pend_k_in;
      op_ff      <= op_in;
      key_ff     <= key_in;
      info_ff    <= info_in;
      present_ff <= present_in;
      status_ff  <= status_in;
      pid_ff     <= pid_in;
      pinfo_ff   <= pinfo_in;
      found_ff   <= found_in;
      pos_ff     <= pos_in;
      next_ff    <= next_in;
      if (cmd.load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_pid_ff    <= pid_ff;
         rsp_pinfo_ff  <= pinfo_ff;
         rsp_found_ff  <= found_ff;
         rsp_pos_ff    <= pos_ff;
         rsp_next_ff   <= next_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_status      = rsp_status_ff;
   assign rsp_pulled_id   = rsp_pid_ff;
   assign rsp_pulled_info = rsp_pinfo_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_next_id     = rsp_next_ff;
   assign rsp_entry_count = fllq_pkg::COUNT_W'(rsp_count_ff);

`ifndef ASSERT_OFF
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      cmd.push_write |-> (count_ff < CW'(DEPTH)))
      else $error("push written into a full store");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (count_ff == '0 && oldest_ff == '0))
      else $error("clear did not empty the store");

   a_pull_decrements: assert property (@(posedge clock) disable iff (reset)
      cmd.pull_take |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pull did not remove exactly one entry");

   a_found_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.set_found |-> (pend_ff && pend_k_ff < count_ff))
      else $error("find hit outside the stored entries");
`endif

endmodule
